### rtl/core/dllp_pkg.sv
`timescale 1ns / 1ps
package dllp_pkg;
    localparam int POOL_NODES = 1024;
    localparam int SLOT_W     = $clog2(POOL_NODES);
    localparam int LINK_W     = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_INSERT = 2'd1,
        K_FIND   = 2'd2,
        K_REMOVE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_LIVE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        kind;
        logic [9:0]        handle;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] result_handle;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_FWD_WR,
        S_BACK_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_OUT
    } t_state;

    // One write to the node memory
    typedef struct packed {
        logic              wr_data;
        logic              wr_next;
        logic              wr_prev;
        logic              wr_live;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic              live;
    } t_mem_wr;
endpackage

### rtl/core/dllp_node_mem.sv
`timescale 1ns / 1ps
module dllp_node_mem (
    input  logic                       i_clk,
    input  logic [dllp_pkg::SLOT_W-1:0] i_rd_addr,
    input  dllp_pkg::t_mem_wr          i_wr,
    output logic [31:0]                o_x,
    output logic [31:0]                o_y,
    output logic [dllp_pkg::LINK_W-1:0] o_next,
    output logic [dllp_pkg::LINK_W-1:0] o_prev,
    output logic                       o_live
);
    import dllp_pkg::*;

    logic [31:0]       m_x    [POOL_NODES];
    logic [31:0]       m_y    [POOL_NODES];
    logic [LINK_W-1:0] m_next [POOL_NODES];
    logic [LINK_W-1:0] m_prev [POOL_NODES];
    logic              m_live [POOL_NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_data) begin
            m_x[i_wr.addr] <= i_wr.x;
            m_y[i_wr.addr] <= i_wr.y;
        end
        if (i_wr.wr_next) m_next[i_wr.addr] <= i_wr.next;
        if (i_wr.wr_prev) m_prev[i_wr.addr] <= i_wr.prev;
        if (i_wr.wr_live) m_live[i_wr.addr] <= i_wr.live;
        o_x    <= m_x[i_rd_addr];
        o_y    <= m_y[i_rd_addr];
        o_next <= m_next[i_rd_addr];
        o_prev <= m_prev[i_rd_addr];
        o_live <= m_live[i_rd_addr];
    end
endmodule

### rtl/core/doubly_linked_list_pool_unit.sv
`timescale 1ns / 1ps
// Doubly linked list of (x, y) pairs in a pool of POOL_NODES slots.
// Request channel i_req_* carries one word: kind, handle, x_value, y_value.
// Response channel o_rsp_* returns one word per request: status, handle.
// Slots come from a bump allocator and are never reused before reset.
// Steps from input accept to response valid:
//   append, insert, remove: decode, forward link write, back link write;
//   any refused request: decode only; find: decode, then per node walked
//   one read of the node memory then one compare.
// One request is in flight at a time; the unit is ready for the next word
// in the cycle after the response is accepted.
// Node data, links and live bits sit in one synchronous memory with one
// read port; the handle node is read as the request is accepted.
// A live bit counts only below the allocator, so reset needs no clearing
// pass: every slot below it was rewritten when it was handed out.
// Reset empties the list and zeroes the allocator.
// A stalled response holds in the output register, and the next request
// is not taken until that response is accepted.
module doubly_linked_list_pool_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  dllp_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output dllp_pkg::t_rsp   o_rsp
);
    import dllp_pkg::*;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;
    logic [LINK_W-1:0] r_head, n_head, r_tail, n_tail, r_alloc, n_alloc;
    logic [LINK_W-1:0] r_cur, n_cur, r_steps, n_steps, r_after, n_after;
    logic [SLOT_W-1:0] rd_addr;
    t_mem_wr           wr;
    logic [31:0]       m_x, m_y;
    logic [LINK_W-1:0] m_next, m_prev;
    logic              m_live;
    logic              full;
    logic              handle_live;
    logic [LINK_W-1:0] new_link;

    dllp_node_mem u_mem (
        .i_clk    (i_clk),
        .i_rd_addr(rd_addr),
        .i_wr     (wr),
        .o_x      (m_x),
        .o_y      (m_y),
        .o_next   (m_next),
        .o_prev   (m_prev),
        .o_live   (m_live)
    );

    assign full        = (r_alloc == LINK_W'(POOL_NODES));
    assign handle_live = ({1'b0, r_req.handle} < r_alloc) && m_live;
    assign new_link    = {1'b0, r_rsp.result_handle};
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_LINK;
            r_tail  <= NULL_LINK;
            r_alloc <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_alloc <= n_alloc;
        end
        r_req   <= n_req;
        r_rsp   <= n_rsp;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_after <= n_after;
    end

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_rsp   = r_rsp;
        n_head  = r_head;
        n_tail  = r_tail;
        n_alloc = r_alloc;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_after = r_after;
        rd_addr = r_cur[SLOT_W-1:0];
        wr = '0;
        wr.addr = r_alloc[SLOT_W-1:0];
        wr.x = r_req.x_value;
        wr.y = r_req.y_value;
        wr.next = NULL_LINK;
        wr.prev = NULL_LINK;
        wr.live = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                // read the handle node so its links and live bit are ready at decode
                rd_addr = i_req.handle;
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_rsp = '{status: ST_OK, result_handle: '0};
                n_cur = NULL_LINK;
                n_after = NULL_LINK;
                unique case (t_kind'(r_req.kind))
                    K_APPEND, K_INSERT: begin
                        if (r_req.kind == K_INSERT && !handle_live) begin
                            n_rsp.status = ST_NOT_LIVE;
                            n_state = S_OUT;
                        end else if (full) begin
                            n_rsp.status = ST_FULL;
                            n_state = S_OUT;
                        end else begin
                            // fill the new node at the allocator slot
                            wr.wr_data = 1'b1;
                            wr.wr_next = 1'b1;
                            wr.wr_prev = 1'b1;
                            wr.wr_live = 1'b1;
                            n_rsp.result_handle = r_alloc[SLOT_W-1:0];
                            n_alloc = r_alloc + LINK_W'(1);
                            n_state = S_FWD_WR;
                            if (r_req.kind == K_APPEND
                                || {1'b0, r_req.handle} == r_tail) begin
                                // link new node after the tail
                                wr.prev = r_tail;
                                n_cur = r_tail;
                                n_tail = r_alloc;
                                if (r_tail == NULL_LINK) n_head = r_alloc;
                            end else begin
                                // new node sits between handle and its old next
                                wr.next = m_next;
                                wr.prev = {1'b0, r_req.handle};
                                n_cur = {1'b0, r_req.handle};
                                n_after = m_next;
                            end
                        end
                    end
                    K_FIND: begin
                        n_cur = r_head;
                        n_steps = '0;
                        if (r_head == NULL_LINK) begin
                            n_rsp.status = ST_NOT_FOUND;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_FIND_RD;
                        end
                    end
                    default: begin
                        if (!handle_live) begin
                            n_rsp.status = ST_NOT_LIVE;
                            n_state = S_OUT;
                        end else begin
                            // drop the live bit, then splice neighbors together
                            wr.wr_live = 1'b1;
                            wr.addr = r_req.handle;
                            wr.live = 1'b0;
                            n_rsp.result_handle = r_req.handle;
                            n_cur = m_prev;
                            n_after = m_next;
                            if (m_prev == NULL_LINK) n_head = m_next;
                            if (m_next == NULL_LINK) n_tail = m_prev;
                            n_state = S_FWD_WR;
                        end
                    end
                endcase
            end
            S_FWD_WR: begin
                // point the predecessor forward
                if (r_cur != NULL_LINK) begin
                    wr.wr_next = 1'b1;
                    wr.addr = r_cur[SLOT_W-1:0];
                    wr.next = (r_req.kind == K_REMOVE) ? r_after : new_link;
                end
                n_state = S_BACK_WR;
            end
            S_BACK_WR: begin
                // fix back link of the following node
                if (r_after != NULL_LINK) begin
                    wr.wr_prev = 1'b1;
                    wr.addr = r_after[SLOT_W-1:0];
                    wr.prev = (r_req.kind == K_REMOVE) ? r_cur : new_link;
                end
                n_state = S_OUT;
            end
            S_FIND_RD: begin
                rd_addr = r_cur[SLOT_W-1:0];
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (m_x == r_req.x_value && m_y == r_req.y_value) begin
                    n_rsp.result_handle = r_cur[SLOT_W-1:0];
                    n_state = S_OUT;
                end else if (m_next == NULL_LINK
                             || r_steps == LINK_W'(POOL_NODES - 1)) begin
                    n_rsp.status = ST_NOT_FOUND;
                    n_state = S_OUT;
                end else begin
                    n_cur = m_next;
                    n_steps = r_steps + LINK_W'(1);
                    n_state = S_FIND_RD;
                end
            end
            S_OUT: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // allocator never moves backward
    a_alloc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc >= $past(r_alloc)) else $error("allocator rewound");
    // head and tail are null together
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NULL_LINK) == (r_tail == NULL_LINK)) else $error("head/tail mismatch");
    // allocator stays within the pool
    a_alloc_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= LINK_W'(POOL_NODES)) else $error("allocator overflow");
    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped while stalled");
endmodule

### tb/dllp_checker.sv
`timescale 1ns / 1ps
module dllp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  dllp_pkg::t_req  i_req,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  dllp_pkg::t_rsp  i_rsp,
    output int              o_fail_count,
    output int              o_pending
);
    import dllp_pkg::*;

    localparam int NULL_SLOT = POOL_NODES;

    logic [31:0] node_x [POOL_NODES];
    logic [31:0] node_y [POOL_NODES];
    int          node_next [POOL_NODES];
    int          node_prev [POOL_NODES];
    bit          node_live [POOL_NODES] = '{default: 1'b0};
    int          list_head = NULL_SLOT;
    int          list_tail = NULL_SLOT;
    int          slots_used = 0;
    int          fail_count = 0;
    int          pending = 0;
    t_rsp        expected_words[$];

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic int grab_slot(input logic [31:0] x, input logic [31:0] y);
        int s;
        s = slots_used;
        slots_used++;
        node_x[s] = x;
        node_y[s] = y;
        node_next[s] = NULL_SLOT;
        node_prev[s] = NULL_SLOT;
        node_live[s] = 1'b1;
        return s;
    endfunction

    function automatic int link_at_tail(input logic [31:0] x, input logic [31:0] y);
        int s;
        s = grab_slot(x, y);
        if (list_tail == NULL_SLOT) begin
            list_head = s;
        end else begin
            node_next[list_tail] = s;
            node_prev[s] = list_tail;
        end
        list_tail = s;
        return s;
    endfunction

    function automatic t_rsp apply_request(input t_req rq);
        t_rsp r;
        int   h, s, cur, steps, p, n;
        r = '0;
        h = rq.handle;
        case (t_kind'(rq.kind))
            K_APPEND: begin
                if (slots_used >= POOL_NODES) r.status = ST_FULL;
                else r.result_handle = 10'(link_at_tail(rq.x_value, rq.y_value));
            end
            K_INSERT: begin
                if (!node_live[h]) begin
                    r.status = ST_NOT_LIVE;
                end else if (slots_used >= POOL_NODES) begin
                    r.status = ST_FULL;
                end else if (h == list_tail) begin
                    r.result_handle = 10'(link_at_tail(rq.x_value, rq.y_value));
                end else begin
                    n = node_next[h];
                    s = grab_slot(rq.x_value, rq.y_value);
                    node_next[s] = n;
                    node_prev[s] = h;
                    node_next[h] = s;
                    if (n != NULL_SLOT) node_prev[n] = s;
                    r.result_handle = 10'(s);
                end
            end
            K_FIND: begin
                cur = list_head;
                steps = 0;
                r.status = ST_NOT_FOUND;
                while (cur != NULL_SLOT && steps < POOL_NODES) begin
                    if (node_x[cur] == rq.x_value && node_y[cur] == rq.y_value) begin
                        r.status = ST_OK;
                        r.result_handle = 10'(cur);
                        break;
                    end
                    cur = node_next[cur];
                    steps++;
                end
            end
            default: begin
                if (!node_live[h]) begin
                    r.status = ST_NOT_LIVE;
                end else begin
                    p = node_prev[h];
                    n = node_next[h];
                    if (p != NULL_SLOT) node_next[p] = n;
                    else list_head = n;
                    if (n != NULL_SLOT) node_prev[n] = p;
                    else list_tail = p;
                    node_live[h] = 1'b0;
                    r.result_handle = 10'(h);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) expected_words.push_back(apply_request(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("response word with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, want.status));
                    if (i_rsp.result_handle !== want.result_handle)
                        report_mismatch($sformatf("handle %0d, expected %0d",
                                                  i_rsp.result_handle, want.result_handle));
                end
            end
            pending <= expected_words.size();
        end
    end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dllp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_word = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_word;
    int   fail_count;
    int   pending;
    // Drop idling while this is set, so back-to-back words get exercised too.
    bit   steady = 1'b0;
    int   live_handles[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    doubly_linked_list_pool_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_ready(req_ready), .i_req(req_word),
        .o_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .o_rsp(rsp_word)
    );

    dllp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .i_req_ready(req_ready), .i_req(req_word),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .i_rsp(rsp_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: set ready at random on each falling edge, held high while steady is set.
    always @(negedge i_clk) begin
        rsp_ready <= steady || ($urandom_range(99) >= 34);
    end

    // Present one word and hold it until the handshake; valid is lowered only
    // for an idle gap before the next word (which otherwise simply replaces it).
    task automatic send_word(input t_kind k, input logic [9:0] h,
                             input logic [31:0] x, input logic [31:0] y);
        while (!steady && $urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_word <= '{kind: k, handle: h, x_value: x, y_value: y};
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (k == K_APPEND || k == K_INSERT) live_handles.push_back(-1);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // Mostly handles that are likely live; sometimes any 10-bit value.
    function automatic logic [9:0] pick_handle(input int used);
        if (used > 0 && $urandom_range(99) < 80) return 10'($urandom_range(used - 1));
        return 10'($urandom);
    endfunction

    initial begin
        int used;
        int k;
        logic [31:0] x, y;
        used = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list cases, extremes, insert after tail and middle,
        // remove the only node, remove head/tail, dead handles.
        send_word(K_FIND, 10'd0, 32'h0, 32'h0);
        send_word(K_REMOVE, 10'd0, 32'h0, 32'h0);
        send_word(K_INSERT, 10'd0, 32'h0, 32'h0);
        send_word(K_APPEND, 10'h3FF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(K_FIND, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(K_FIND, 10'd0, 32'h8000_0000, 32'h7FFF_FFFE);
        send_word(K_REMOVE, 10'd0, 32'h0, 32'h0);
        send_word(K_FIND, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(K_REMOVE, 10'd0, 32'h0, 32'h0);
        send_word(K_APPEND, 10'd0, 32'hFFFF_FFFF, 32'h0);
        send_word(K_INSERT, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(K_APPEND, 10'd0, 32'h5, 32'h5);
        send_word(K_INSERT, 10'd1, 32'h5, 32'h5);
        send_word(K_FIND, 10'd0, 32'h5, 32'h5);
        send_word(K_REMOVE, 10'd4, 32'h0, 32'h0);
        send_word(K_FIND, 10'd0, 32'h5, 32'h5);
        send_word(K_REMOVE, 10'd1, 32'h0, 32'h0);
        send_word(K_REMOVE, 10'd3, 32'h0, 32'h0);
        send_word(K_INSERT, 10'h3FF, 32'h1, 32'h1);
        send_word(K_REMOVE, 10'h2AA, 32'h0, 32'h0);
        send_word(K_INSERT, 10'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        used = live_handles.size();

        // Random: random gaps, with a stretch of no idling in the middle.
        for (int i = 0; i < 620; i++) begin
            steady = (i >= 60 && i < 160);
            k = $urandom_range(99);
            x = pick_value();
            y = pick_value();
            if (k < 35) send_word(K_APPEND, 10'($urandom), x, y);
            else if (k < 55) send_word(K_INSERT, pick_handle(used), x, y);
            else if (k < 80) send_word(K_FIND, 10'($urandom), x, y);
            else send_word(K_REMOVE, pick_handle(used), x, y);
            used = live_handles.size();
        end
        steady = 1'b0;

        // Close with a few words on arbitrary handles.
        send_word(K_INSERT, 10'd2, 32'h1, 32'h1);
        send_word(K_INSERT, 10'd1000, 32'h1, 32'h1);
        send_word(K_FIND, 10'd0, 32'hDEAD_BEEF, 32'h1234_5678);
        send_word(K_REMOVE, 10'd1023, 32'h0, 32'h0);
        send_word(K_APPEND, 10'd0, 32'h1, 32'h1);
        req_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
